// ----- src/gmc_pkg.sv -----
// shared constants for the genotype match counter
`default_nettype none
package gmc_pkg;
    localparam int unsigned GENO_W     = 64;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned CODE_W     = 2;
    localparam int unsigned GROUP_SIZE = 8;
    localparam int unsigned GRP_W      = 4;

    localparam logic [CODE_W-1:0]  CODE_MISSING = 2'b01;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
endpackage
`default_nettype wire

// ----- src/gmc_lane.sv -----
// one lane: match test of two genotype codes
`default_nettype none
module gmc_lane (
    input  wire logic [gmc_pkg::CODE_W-1:0] i_code_a,
    input  wire logic [gmc_pkg::CODE_W-1:0] i_code_b,
    output logic                            o_hit
);
    import gmc_pkg::*;

    // equal codes, and a missing one on either side means both are missing
    assign o_hit = (i_code_a == i_code_b) && (i_code_a != CODE_MISSING);
endmodule
`default_nettype wire

// ----- src/gmc_merge.sv -----
// merge stage: group popcounts, saturating accumulator, output register
`default_nettype none
module gmc_merge #(
    parameter int unsigned LANES = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [LANES-1:0]           i_hits,
    input  wire logic                       i_last_word,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [gmc_pkg::COUNT_W-1:0]     o_match_count
);
    import gmc_pkg::*;

    localparam int unsigned NGROUPS = (LANES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int unsigned PAD_W   = NGROUPS * GROUP_SIZE;
    localparam int unsigned POP_W   = $clog2(LANES + 1);

    logic [PAD_W-1:0]  hits_pad;
    logic [GRP_W-1:0]  n_grp [NGROUPS];
    logic [GRP_W-1:0]  r_grp [NGROUPS];
    logic              r_s1_valid;
    logic              r_s1_last;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_out_count;
    logic              r_out_valid;
    logic              out_free;
    logic              s1_adv;
    logic [POP_W-1:0]  pop;
    logic [COUNT_W:0]  sum_wide;
    logic [COUNT_W-1:0] sum_sat;

    assign hits_pad = PAD_W'(i_hits);

    // per-group counts of eight lanes each
    always_comb begin
        for (int g = 0; g < NGROUPS; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                n_grp[g] = n_grp[g] + GRP_W'(hits_pad[g*GROUP_SIZE + k]);
            end
        end
    end

    always_comb begin
        pop = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            pop = pop + POP_W'(r_grp[g]);
        end
    end

    assign sum_wide = {1'b0, r_count} + (COUNT_W+1)'(pop);
    assign sum_sat  = sum_wide[COUNT_W] ? COUNT_MAX : sum_wide[COUNT_W-1:0];

    assign out_free = !r_out_valid || i_ready;
    assign s1_adv   = r_s1_valid && (!r_s1_last || out_free);
    assign o_ready  = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_last   <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
                r_s1_last  <= i_last_word;
            end
            // a new result reloads the output as the old one leaves
            if (s1_adv && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_adv) begin
                if (r_s1_last) begin
                    r_count <= '0;
                end else begin
                    r_count <= sum_sat;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_grp <= n_grp;
        end
        if (s1_adv && r_s1_last) begin
            r_out_count <= sum_sat;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_match_count = r_out_count;
endmodule
`default_nettype wire

// ----- src/genotype_match_counter.sv -----
// top level of the genotype match counter
//
// input channel (i_valid / o_ready): one beat carries LANES two-bit codes of
// each individual in i_geno_a / i_geno_b, lane i in bits 2i+1:2i, and
// i_last_word marking the final beat of a pair
// a lane matches when both codes are equal and not the missing code 01;
// lanes at and above LANES are ignored, so pad a short tail with 01
// output channel (o_valid / i_ready): one beat per last word, carrying the
// pair's match count including that word, saturating at 2^32-1
// path: a last beat's count passes two register stages (lane hits with group
// popcounts, then the accumulator and output register) before o_valid
// throughput: one beat per cycle, set by the accumulator add, while no last
// beat waits on a held result
// stall: while a result waits, non-last beats keep flowing into the count;
// a second last beat holds in the first stage and o_ready drops until the
// waiting result is taken
// reset: synchronous active low; clears the count and both valid flags
`default_nettype none
module genotype_match_counter #(
    parameter int unsigned LANES = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [gmc_pkg::GENO_W-1:0]  i_geno_a,
    input  wire logic [gmc_pkg::GENO_W-1:0]  i_geno_b,
    input  wire logic                        i_last_word,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [gmc_pkg::COUNT_W-1:0]      o_match_count
);
    import gmc_pkg::*;

    logic [LANES-1:0] hits;

    // one compare lane per genotype code
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        gmc_lane u_lane (
            .i_code_a (i_geno_a[CODE_W*l +: CODE_W]),
            .i_code_b (i_geno_b[CODE_W*l +: CODE_W]),
            .o_hit    (hits[l])
        );
    end

    // popcount, accumulate, saturate and present the result
    gmc_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_hits        (hits),
        .i_last_word   (i_last_word),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_match_count (o_match_count)
    );
endmodule
`default_nettype wire

// ----- src/gmc_checker.sv -----
// port-level checks for the genotype match counter, bound to the top level
`default_nettype none
module gmc_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_valid,
    input wire logic                        o_ready,
    input wire logic                        i_last_word,
    input wire logic                        o_valid,
    input wire logic                        i_ready,
    input wire logic [gmc_pkg::COUNT_W-1:0] o_match_count
);
    import gmc_pkg::*;

    // a waiting result holds its count
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_match_count))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result valid after reset");

    // a fresh result must trace back to an accepted last beat
    a_rose_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready && i_last_word, 2))
        else $error("result without a last beat");

    // input backpressure only while a result is stalled
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without output stall");
endmodule

bind genotype_match_counter gmc_checker u_gmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_last_word   (i_last_word),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_match_count (o_match_count)
);
`default_nettype wire

// ----- tb/sv/match_count_checker.sv -----
// checker that predicts and compares the match counts of the genotype match counter
`default_nettype none
module match_count_checker #(
    parameter int unsigned LANES = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_ready,
    input  wire logic [gmc_pkg::GENO_W-1:0]  i_geno_a,
    input  wire logic [gmc_pkg::GENO_W-1:0]  i_geno_b,
    input  wire logic                        i_last_word,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic [gmc_pkg::COUNT_W-1:0] i_match_count,
    output int                               o_fail_count,
    output int                               o_pending
);
    logic [gmc_pkg::COUNT_W-1:0] pair_count = '0;
    logic [gmc_pkg::COUNT_W-1:0] expected_counts [$];
    int                          mismatches = 0;

    assign o_fail_count = mismatches;

    // lanes with equal codes, missing excluded, lanes at and above LANES ignored
    function automatic int unsigned lane_matches(
        input logic [gmc_pkg::GENO_W-1:0] a,
        input logic [gmc_pkg::GENO_W-1:0] b
    );
        int unsigned n;
        n = 0;
        for (int unsigned lane = 0; lane < LANES; lane++) begin
            if (a[gmc_pkg::CODE_W*lane +: gmc_pkg::CODE_W] ==
                    b[gmc_pkg::CODE_W*lane +: gmc_pkg::CODE_W] &&
                    a[gmc_pkg::CODE_W*lane +: gmc_pkg::CODE_W] != gmc_pkg::CODE_MISSING) begin
                n++;
            end
        end
        return n;
    endfunction

    task automatic report_mismatch(
        input string                       what,
        input logic [gmc_pkg::COUNT_W-1:0] got,
        input logic [gmc_pkg::COUNT_W-1:0] want
    );
        $display("mismatch: %s, got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : track
        logic [gmc_pkg::COUNT_W:0]   sum;
        logic [gmc_pkg::COUNT_W-1:0] want;
        if (!i_rst_n) begin
            pair_count = '0;
            expected_counts.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_counts.size() == 0) begin
                    report_mismatch("match count with no pair pending", i_match_count, '0);
                end else begin
                    want = expected_counts.pop_front();
                    if (i_match_count !== want) begin
                        report_mismatch("match count", i_match_count, want);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                sum = {1'b0, pair_count} +
                      (gmc_pkg::COUNT_W+1)'(lane_matches(i_geno_a, i_geno_b));
                // saturate at the top of the count
                if (sum > {1'b0, gmc_pkg::COUNT_MAX}) begin
                    sum = {1'b0, gmc_pkg::COUNT_MAX};
                end
                if (i_last_word) begin
                    expected_counts.push_back(sum[gmc_pkg::COUNT_W-1:0]);
                    pair_count = '0;
                end else begin
                    pair_count = sum[gmc_pkg::COUNT_W-1:0];
                end
            end
        end
        o_pending <= expected_counts.size();
    end
endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// top of the genotype match counter testbench: stimulus, handshake pacing and verdict
`default_nettype none
module testbench;
    // lane count of the block under test, shared with the checker
    localparam int unsigned LANES        = 32;
    localparam int unsigned ALL_LANES    = gmc_pkg::GENO_W / gmc_pkg::CODE_W;
    localparam int          RESET_CYCLES = 9;
    // random beats per pacing phase, four phases
    localparam int          PHASE_ITEMS  = 175;
    // drain after the last result, well past the two stage latency
    localparam int          DRAIN_CYCLES = 16;
    localparam int          CYCLE_LIMIT  = 400000;

    // genotype codes other than the missing one
    localparam logic [gmc_pkg::CODE_W-1:0] CODE_HOM_REF = 2'b00;
    localparam logic [gmc_pkg::CODE_W-1:0] CODE_HET     = 2'b10;
    localparam logic [gmc_pkg::CODE_W-1:0] CODE_HOM_ALT = 2'b11;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_valid     = 1'b0;
    logic                        o_ready;
    logic [gmc_pkg::GENO_W-1:0]  i_geno_a    = '0;
    logic [gmc_pkg::GENO_W-1:0]  i_geno_b    = '0;
    logic                        i_last_word = 1'b0;
    logic                        o_valid;
    logic                        i_ready     = 1'b0;
    logic [gmc_pkg::COUNT_W-1:0] o_match_count;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int items_sent  = 0;
    // percent of cycles the sender idles / the receiver stalls
    int idle_pct    = 0;
    int stall_pct   = 0;

    // 20 unit clock period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    genotype_match_counter #(
        .LANES(LANES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_geno_a      (i_geno_a),
        .i_geno_b      (i_geno_b),
        .i_last_word   (i_last_word),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_match_count (o_match_count)
    );

    match_count_checker #(
        .LANES(LANES)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_geno_a      (i_geno_a),
        .i_geno_b      (i_geno_b),
        .i_last_word   (i_last_word),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_match_count (o_match_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // receiver side: ready drops at random per the current stall rate
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // hard stop in case the handshake hangs
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // one beat on the input channel; valid stays up across back to back beats
    // and only drops when an idle gap is drawn
    task automatic send_beat(
        input logic [gmc_pkg::GENO_W-1:0] a,
        input logic [gmc_pkg::GENO_W-1:0] b,
        input logic                       is_last
    );
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_geno_a    <= a;
        i_geno_b    <= b;
        i_last_word <= is_last;
        // hold the payload until the block takes it
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        items_sent++;
    endtask

    initial begin
        logic [gmc_pkg::GENO_W-1:0] a;
        logic [gmc_pkg::GENO_W-1:0] b;
        int                         n_words;
        int                         mode;
        int                         tail;
        int                         quota;

        // reset once at the start, never again
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling
        // all lanes equal for each code: full match except for missing
        send_beat({ALL_LANES{CODE_HOM_REF}}, {ALL_LANES{CODE_HOM_REF}}, 1'b1);
        send_beat({ALL_LANES{CODE_HOM_ALT}}, {ALL_LANES{CODE_HOM_ALT}}, 1'b1);
        send_beat({ALL_LANES{CODE_HET}}, {ALL_LANES{CODE_HET}}, 1'b1);
        send_beat({ALL_LANES{gmc_pkg::CODE_MISSING}},
                  {ALL_LANES{gmc_pkg::CODE_MISSING}}, 1'b1);
        // never equal
        send_beat({ALL_LANES{CODE_HOM_REF}}, {ALL_LANES{CODE_HOM_ALT}}, 1'b1);
        send_beat({ALL_LANES{CODE_HET}}, {ALL_LANES{CODE_HOM_ALT}}, 1'b1);
        // missing on one side only
        send_beat({ALL_LANES{gmc_pkg::CODE_MISSING}}, {ALL_LANES{CODE_HOM_REF}}, 1'b1);
        send_beat({ALL_LANES{CODE_HOM_REF}}, {ALL_LANES{gmc_pkg::CODE_MISSING}}, 1'b1);
        // multi word pair accumulates across beats
        send_beat({ALL_LANES{CODE_HOM_REF}}, {ALL_LANES{CODE_HOM_REF}}, 1'b0);
        send_beat({ALL_LANES{CODE_HET}}, {ALL_LANES{CODE_HET}}, 1'b0);
        send_beat({ALL_LANES{CODE_HOM_ALT}}, {ALL_LANES{CODE_HOM_ALT}}, 1'b0);
        send_beat({ALL_LANES{CODE_HOM_REF}}, {ALL_LANES{CODE_HOM_REF}}, 1'b1);
        // short tail padded with the missing code
        send_beat({{24{gmc_pkg::CODE_MISSING}}, {8{CODE_HET}}},
                  {{24{gmc_pkg::CODE_MISSING}}, {8{CODE_HET}}}, 1'b1);
        // single match in the top lane, then in the bottom lane
        send_beat({CODE_HOM_ALT, {(ALL_LANES-1){gmc_pkg::CODE_MISSING}}},
                  {CODE_HOM_ALT, {(ALL_LANES-1){gmc_pkg::CODE_MISSING}}}, 1'b1);
        send_beat({{(ALL_LANES-1){gmc_pkg::CODE_MISSING}}, CODE_HET},
                  {{(ALL_LANES-1){gmc_pkg::CODE_MISSING}}, CODE_HET}, 1'b1);
        // mixed codes, partially equal, over two words
        send_beat(64'h0123_4567_89ab_cdef, 64'h0123_4567_89ab_cdef, 1'b0);
        send_beat(64'hfedc_ba98_7654_3210, 64'hfedc_ba98_0000_ffff, 1'b1);
        // count cleared after each last word: lone zero-match pair
        send_beat(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b1);

        // random part in four pacing phases
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 46;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 46;
                end
                default: begin
                    idle_pct  = 28;
                    stall_pct = 28;
                end
            endcase
            quota = items_sent + PHASE_ITEMS;
            while (items_sent < quota) begin
                // mostly short pairs, some longer ones
                if ($urandom_range(0, 9) < 6) begin
                    n_words = $urandom_range(1, 4);
                end else begin
                    n_words = $urandom_range(5, 12);
                end
                for (int w = 0; w < n_words; w++) begin
                    mode = $urandom_range(0, 9);
                    a = {$urandom, $urandom};
                    b = {$urandom, $urandom};
                    case (mode)
                        0, 1, 2, 3: begin
                            // related individuals: most lanes copied
                            for (int lane = 0; lane < ALL_LANES; lane++) begin
                                if ($urandom_range(0, 7) != 0) begin
                                    b[gmc_pkg::CODE_W*lane +: gmc_pkg::CODE_W] =
                                        a[gmc_pkg::CODE_W*lane +: gmc_pkg::CODE_W];
                                end
                            end
                        end
                        4: begin
                            b = a;
                        end
                        5: begin
                            // tail word: lanes from the cut upward padded as missing
                            tail = $urandom_range(0, ALL_LANES - 1);
                            for (int lane = 0; lane < ALL_LANES; lane++) begin
                                if (lane >= tail) begin
                                    a[gmc_pkg::CODE_W*lane +: gmc_pkg::CODE_W] =
                                        gmc_pkg::CODE_MISSING;
                                    b[gmc_pkg::CODE_W*lane +: gmc_pkg::CODE_W] =
                                        gmc_pkg::CODE_MISSING;
                                end else if ($urandom_range(0, 3) != 0) begin
                                    b[gmc_pkg::CODE_W*lane +: gmc_pkg::CODE_W] =
                                        a[gmc_pkg::CODE_W*lane +: gmc_pkg::CODE_W];
                                end
                            end
                        end
                        6: begin
                            // one side entirely missing
                            if ($urandom_range(0, 1) != 0) begin
                                a = {ALL_LANES{gmc_pkg::CODE_MISSING}};
                            end else begin
                                b = {ALL_LANES{gmc_pkg::CODE_MISSING}};
                            end
                        end
                        7: begin
                            b = ~a;
                        end
                        default: begin
                            // independent random words
                        end
                    endcase
                    send_beat(a, b, w == n_words - 1);
                end
            end
        end

        // stop sending and let every pending count come out
        i_valid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
src/gmc_pkg.sv
src/gmc_lane.sv
src/gmc_merge.sv
src/genotype_match_counter.sv
src/gmc_checker.sv
tb/sv/match_count_checker.sv
tb/sv/testbench.sv
